// ===== rtl/vrl_pkg.sv =====
`default_nettype none
package vrl_pkg;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned MAG_W     = 32;
  localparam int unsigned SUM_W     = 64;
  localparam int unsigned LEN_W     = 32;
  localparam int unsigned PROD_W    = 64;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned ROOT_CELLS = 32;
  localparam int unsigned DIV_CELLS  = 33;

  typedef struct packed {
    logic                 valid;
    logic                 zero;
    logic [2:0]           flip;
    logic [MAG_W-1:0]     tm;
    logic [3*MAG_W-1:0]   cm;
  } ctl_t;

  // magnitude of a 32-bit two's complement word, 0..2^31
  function automatic logic [MAG_W-1:0] word_mag(input logic [WORD_W-1:0] w);
    logic [MAG_W-1:0] r;
    r = w[WORD_W-1] ? (~w + 1'b1) : w;
    return r;
  endfunction
endpackage
`default_nettype wire

// ===== rtl/vrl_root_cell.sv =====
`default_nettype none
// One step of the bitwise square root: decide one result bit.
module vrl_root_cell (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic [5:0]                step,
  input  wire logic [vrl_pkg::SUM_W-1:0] rem_in,
  input  wire logic [vrl_pkg::LEN_W-1:0] root_in,
  input  wire vrl_pkg::ctl_t             ctl_in,
  output      logic [vrl_pkg::SUM_W-1:0] rem_out,
  output      logic [vrl_pkg::LEN_W-1:0] root_out,
  output      vrl_pkg::ctl_t             ctl_out
);
  logic [vrl_pkg::SUM_W+1:0] trial;
  logic [vrl_pkg::SUM_W+1:0] cand;
  logic [vrl_pkg::SUM_W+1:0] rem_w;

  always_comb begin
    rem_w = {2'b00, rem_in};
    cand  = ({2'b00, 32'd0, root_in} << (step + 6'd1)) |
            ({{(vrl_pkg::SUM_W+1){1'b0}}, 1'b1} << (step << 1));
    trial = rem_w - cand;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else begin
      ctl_out.valid <= ctl_in.valid;
    end
    ctl_out.zero <= ctl_in.zero;
    ctl_out.flip <= ctl_in.flip;
    ctl_out.tm   <= ctl_in.tm;
    ctl_out.cm   <= ctl_in.cm;
    if (rem_w >= cand) begin
      rem_out  <= trial[vrl_pkg::SUM_W-1:0];
      root_out <= root_in | (vrl_pkg::LEN_W'(1) << step[4:0]);
    end else begin
      rem_out  <= rem_in;
      root_out <= root_in;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/vrl_div_cell.sv =====
`default_nettype none
// One restoring division step for three dividends sharing one divisor.
module vrl_div_cell (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic [5:0]                 step,
  input  wire logic [vrl_pkg::LEN_W-1:0]  den,
  input  wire logic [3*vrl_pkg::PROD_W-1:0] num_in,
  input  wire logic [3*vrl_pkg::LEN_W+2:0]  rem_in,
  input  wire logic [3*vrl_pkg::LEN_W+2:0]  quo_in,
  input  wire logic                       valid_in,
  input  wire logic                       zero_in,
  input  wire logic [2:0]                 flip_in,
  output      logic [vrl_pkg::LEN_W-1:0]  den_out,
  output      logic [3*vrl_pkg::PROD_W-1:0] num_out,
  output      logic [3*vrl_pkg::LEN_W+2:0]  rem_out,
  output      logic [3*vrl_pkg::LEN_W+2:0]  quo_out,
  output      logic                       valid_out,
  output      logic                       zero_out,
  output      logic [2:0]                 flip_out
);
  localparam int unsigned RW = vrl_pkg::LEN_W + 1;
  logic [RW-1:0] r_sh [3];
  logic [RW-1:0] r_nx [3];
  logic [2:0]    q_bit;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      // shift in the next numerator bit, then compare against the length
      r_sh[k] = {rem_in[k*RW +: RW-1],
                 num_in[k*vrl_pkg::PROD_W + 32 - int'(step)]};
      q_bit[k] = (r_sh[k] >= {1'b0, den});
      r_nx[k]  = q_bit[k] ? (r_sh[k] - {1'b0, den}) : r_sh[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= valid_in;
    end
    den_out  <= den;
    num_out  <= num_in;
    zero_out <= zero_in;
    flip_out <= flip_in;
    for (int k = 0; k < 3; k++) begin
      rem_out[k*RW +: RW] <= r_nx[k];
      quo_out[k*RW +: RW] <= {quo_in[k*RW +: RW-1], q_bit[k]};
    end
  end
endmodule
`default_nettype wire

// ===== rtl/vector_rescale_to_length_3d_top.sv =====
`default_nettype none
// From start to done an item passes the input register, squares, sum,
// 32 root cells, products, 33 divider cells, and sign and clamp into the output
// register. Throughput: one item per cycle; busy is held low, so an item
// may follow every cycle. The root and divider rows set the latency. Reset
// (rst, synchronous) clears every valid bit; payload registers are not
// reset. The receiver cannot stall: done pulses for one cycle per item.
module vector_rescale_to_length_3d_top #(
  parameter int unsigned FRAC_BITS = vrl_pkg::FRAC_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output      logic        busy,
  input  wire logic [31:0] coord_x,
  input  wire logic [31:0] coord_y,
  input  wire logic [31:0] coord_z,
  input  wire logic [31:0] target_length,
  output      logic        done,
  output      logic [31:0] out_x,
  output      logic [31:0] out_y,
  output      logic [31:0] out_z,
  output      logic        zero_vector_error,
  output      logic        saturated
);
  localparam int unsigned NR = vrl_pkg::ROOT_CELLS;
  localparam int unsigned ND = vrl_pkg::DIV_CELLS;
  localparam int unsigned RW = vrl_pkg::LEN_W + 1;
  localparam int unsigned PW = vrl_pkg::PROD_W;

  // FRAC_BITS gives the words their meaning (above 32 no start is taken); the raw
  // arithmetic cancels it, so the width of the fraction leaves every bit untouched.
  logic frac_ok;
  assign frac_ok = (FRAC_BITS <= 32);
  assign busy = 1'b0;

  // stage 1: magnitudes and signs
  vrl_pkg::ctl_t s1;
  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
    end else begin
      s1.valid <= start & frac_ok;
    end
    s1.zero <= (coord_x == 32'd0) && (coord_y == 32'd0) && (coord_z == 32'd0);
    s1.flip <= {coord_z[31] ^ target_length[31], coord_y[31] ^ target_length[31],
                coord_x[31] ^ target_length[31]};
    s1.tm   <= vrl_pkg::word_mag(target_length);
    s1.cm   <= {vrl_pkg::word_mag(coord_z), vrl_pkg::word_mag(coord_y),
                vrl_pkg::word_mag(coord_x)};
  end

  // stage 2: squares, one multiplier each
  vrl_pkg::ctl_t s2;
  logic [63:0] sq [3];
  always_ff @(posedge clk) begin
    if (rst) begin
      s2.valid <= 1'b0;
    end else begin
      s2.valid <= s1.valid;
    end
    s2.zero <= s1.zero;
    s2.flip <= s1.flip;
    s2.tm   <= s1.tm;
    s2.cm   <= s1.cm;
    for (int k = 0; k < 3; k++) begin
      sq[k] <= s1.cm[k*32 +: 32] * s1.cm[k*32 +: 32];
    end
  end

  // stage 3: sum of squares (fits in 64 bits, at most 3*2^62)
  vrl_pkg::ctl_t s3;
  logic [63:0] sum3;
  always_ff @(posedge clk) begin
    if (rst) begin
      s3.valid <= 1'b0;
    end else begin
      s3.valid <= s2.valid;
    end
    s3.zero <= s2.zero;
    s3.flip <= s2.flip;
    s3.tm   <= s2.tm;
    s3.cm   <= s2.cm;
    sum3    <= sq[0] + sq[1] + sq[2];
  end

  // root row: cell i decides bit 31-i of the length
  logic [63:0]   rrem  [NR+1];
  logic [31:0]   rroot [NR+1];
  vrl_pkg::ctl_t rctl  [NR+1];
  assign rrem[0]  = sum3;
  assign rroot[0] = 32'd0;
  assign rctl[0]  = s3;
  for (genvar i = 0; i < NR; i++) begin : g_root
    vrl_root_cell u_cell (
      .clk(clk), .rst(rst), .step(6'(NR - 1 - i)),
      .rem_in(rrem[i]), .root_in(rroot[i]), .ctl_in(rctl[i]),
      .rem_out(rrem[i+1]), .root_out(rroot[i+1]), .ctl_out(rctl[i+1])
    );
  end

  // product stage: |c| * |t|, up to 2^62
  logic [31:0]        plen;
  logic [3*PW-1:0]    prod;
  logic               pvalid, pzero;
  logic [2:0]         pflip;
  always_ff @(posedge clk) begin
    if (rst) begin
      pvalid <= 1'b0;
    end else begin
      pvalid <= rctl[NR].valid;
    end
    pzero <= rctl[NR].zero;
    pflip <= rctl[NR].flip;
    // hold length at one for a zero vector so the divider stays defined
    plen  <= rctl[NR].zero ? 32'd1 : rroot[NR];
    for (int k = 0; k < 3; k++) begin
      prod[k*PW +: PW] <= rctl[NR].cm[k*32 +: 32] * rctl[NR].tm;
    end
  end

  // divider row: quotient is at most 2^31, so 33 bits from the top
  // partial remainder; numerator bits 32..0 shift in one per cell.
  logic [31:0]       dden [ND+1];
  logic [3*PW-1:0]   dnum [ND+1];
  logic [3*RW-1:0]   drem [ND+1];
  logic [3*RW-1:0]   dquo [ND+1];
  logic              dval [ND+1];
  logic              dzer [ND+1];
  logic [2:0]        dflp [ND+1];
  logic [3*RW-1:0]   rem_init;
  always_comb begin
    // seed each remainder with numerator bits 63..33 (below the length)
    for (int k = 0; k < 3; k++) begin
      rem_init[k*RW +: RW] = {2'b00, prod[k*PW + 33 +: 31]};
    end
  end
  assign dden[0] = plen;
  assign dnum[0] = prod;
  assign drem[0] = rem_init;
  assign dquo[0] = '0;
  assign dval[0] = pvalid;
  assign dzer[0] = pzero;
  assign dflp[0] = pflip;
  for (genvar i = 0; i < ND; i++) begin : g_div
    vrl_div_cell u_cell (
      .clk(clk), .rst(rst), .step(6'(i)), .den(dden[i]),
      .num_in(dnum[i]), .rem_in(drem[i]), .quo_in(dquo[i]),
      .valid_in(dval[i]), .zero_in(dzer[i]), .flip_in(dflp[i]),
      .den_out(dden[i+1]), .num_out(dnum[i+1]), .rem_out(drem[i+1]),
      .quo_out(dquo[i+1]), .valid_out(dval[i+1]), .zero_out(dzer[i+1]),
      .flip_out(dflp[i+1])
    );
  end

  // sign and clamp: only +2^31 overflows
  logic [31:0] res [3];
  logic [2:0]  clamp;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      clamp[k] = 1'b0;
      if (dflp[ND][k]) begin
        res[k] = ~dquo[ND][k*RW +: 32] + 32'd1;
      end else if (dquo[ND][k*RW + 31]) begin
        res[k]   = 32'h7FFF_FFFF;
        clamp[k] = 1'b1;
      end else begin
        res[k] = dquo[ND][k*RW +: 32];
      end
      if (dzer[ND]) begin
        res[k]   = 32'd0;
        clamp[k] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dval[ND];
    end
    out_x             <= res[0];
    out_y             <= res[1];
    out_z             <= res[2];
    zero_vector_error <= dzer[ND];
    saturated         <= |clamp;
  end
endmodule
`default_nettype wire
